@@ rtl/icp_pkg.sv @@
// Package for the intcode processor core: item and result types, status and
// instruction codes, datapath commands and controller/datapath status.
// No dependencies.
package icp_pkg;

    localparam int MEM_WORDS_DEF = 4096;

    // Item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OUT     = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd2;
    localparam logic [2:0] ST_HALT    = 3'd3;
    localparam logic [2:0] ST_BADOP   = 3'd4;
    localparam logic [2:0] ST_BADMODE = 3'd5;
    localparam logic [2:0] ST_BADADDR = 3'd6;

    // Instruction codes (word modulo 100)
    localparam logic [6:0] IC_ADD  = 7'd1;
    localparam logic [6:0] IC_MUL  = 7'd2;
    localparam logic [6:0] IC_IN   = 7'd3;
    localparam logic [6:0] IC_OUT  = 7'd4;
    localparam logic [6:0] IC_JNZ  = 7'd5;
    localparam logic [6:0] IC_JZ   = 7'd6;
    localparam logic [6:0] IC_LT   = 7'd7;
    localparam logic [6:0] IC_EQ   = 7'd8;
    localparam logic [6:0] IC_ARB  = 7'd9;
    localparam logic [6:0] IC_HALT = 7'd99;

    // Parameter mode codes
    localparam logic [3:0] MD_POS = 4'd0;
    localparam logic [3:0] MD_IMM = 4'd1;
    localparam logic [3:0] MD_REL = 4'd2;

    // Divide by ten: q = (x * RECIP) >> SHIFT, exact for any 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          NUM_DIGITS  = 5;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        address;
        logic signed [31:0] value;
        logic               in_valid;
        logic [7:0]         in_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic               input_taken;
        logic signed [31:0] next_pc;
    } result_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR,
        DP_CAPTURE,
        DP_LOAD_WR,
        DP_FETCH,
        DP_WORD,
        DP_DIV_MUL,
        DP_DIV_REM,
        DP_OPND_ADDR,
        DP_OPND_RAW,
        DP_OPND_VAL,
        DP_MUL,
        DP_EXEC,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
        logic       dst;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic       is_step;
        logic       halted;
        logic [2:0] err;
        logic       load_bad;
        logic       fetch_bad;
        logic       word_neg;
        logic [6:0] oc;
        logic       mode_bad;
        logic       imm;
        logic       opnd_bad;
        logic       eff_bad;
        logic       jump_taken;
        logic       in_valid;
        logic       clr_last;
    } dp_stat_t;

endpackage

@@ rtl/icp_chan_if.sv @@
// Valid/ready channel carrying one payload of type T.
// Used with the item and result types of icp_pkg.
interface icp_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/icp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module icp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/icp_datapath.sv @@
// Datapath of the intcode core: word memory, pc, relative base, decode
// digits, operands, shared multiplier and result register.
// Depends on icp_pkg and icp_ram.
module icp_datapath
    import icp_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  item_t    item_data,
    output dp_stat_t stat,
    output result_t  result
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [31:0] LIMIT = 32'(MEM_WORDS);

    logic          step_reg;
    logic [11:0]   addr_reg;
    logic [31:0]   value_reg;
    logic          inv_reg;
    logic [7:0]    inb_reg;
    logic [31:0]   pc_reg;
    logic [31:0]   rb_reg;
    logic          halted_reg;
    logic [2:0]    err_reg;
    logic [AW-1:0] clr_reg;
    logic [31:0]   word_reg;
    logic [31:0]   x_reg;
    logic [63:0]   prod_reg;
    logic [19:0]   dig_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [AW-1:0] d_reg;
    result_t       result_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   rdata;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [28:0]   quot;
    logic [31:0]   quot_x10;
    logic [3:0]    rem;
    logic [6:0]    oc;
    logic [3:0]    mode;
    logic [31:0]   opnd_addr;
    logic [31:0]   eff;
    logic [31:0]   load_addr;
    logic          jump_taken;

    icp_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    // Decode digits and operand addressing
    always_comb
    begin
        quot      = prod_reg[63:DIV10_SHIFT];
        quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem       = 4'(x_reg - quot_x10);
        oc        = {dig_reg[7:4], 3'b000} + {2'b00, dig_reg[7:4], 1'b0}
                    + {3'b000, dig_reg[3:0]};
        case (cmd.idx)
            2'd0:    mode = dig_reg[11:8];
            2'd1:    mode = dig_reg[15:12];
            default: mode = dig_reg[19:16];
        endcase
        opnd_addr  = pc_reg + 32'(cmd.idx) + 32'd1;
        eff        = (mode == MD_REL) ? (rb_reg + rdata) : rdata;
        load_addr  = {20'd0, addr_reg};
        jump_taken = (a_reg != 32'd0) == (oc == IC_JNZ);
    end

    // Status toward the controller
    always_comb
    begin
        stat.is_step    = step_reg;
        stat.halted     = halted_reg;
        stat.err        = err_reg;
        stat.load_bad   = load_addr >= LIMIT;
        stat.fetch_bad  = pc_reg >= LIMIT;
        stat.word_neg   = word_reg[31];
        stat.oc         = oc;
        stat.mode_bad   = cmd.dst ? (mode != MD_POS && mode != MD_REL) : (mode > MD_REL);
        stat.imm        = mode == MD_IMM;
        stat.opnd_bad   = opnd_addr >= LIMIT;
        stat.eff_bad    = eff >= LIMIT;
        stat.jump_taken = jump_taken;
        stat.in_valid   = inv_reg;
        stat.clr_last   = clr_reg == AW'(MEM_WORDS - 1);
    end

    // Memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = d_reg;
        ram_wdata = 32'd0;
        case (cmd.op)
            DP_OPND_ADDR: ram_raddr = opnd_addr[AW-1:0];
            DP_OPND_RAW:  ram_raddr = eff[AW-1:0];
            default:      ram_raddr = pc_reg[AW-1:0];
        endcase
        case (cmd.op)
            DP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            DP_LOAD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = load_addr[AW-1:0];
                ram_wdata = value_reg;
            end
            DP_EXEC:
            begin
                case (oc)
                    IC_ADD:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = a_reg + b_reg;
                    end
                    IC_MUL:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = prod_reg[31:0];
                    end
                    IC_LT:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {31'd0, $signed(a_reg) < $signed(b_reg)};
                    end
                    IC_EQ:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {31'd0, a_reg == b_reg};
                    end
                    IC_IN:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {24'd0, inb_reg};
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Share one multiplier between divide-by-ten and the mul instruction
    assign mul_a = (cmd.op == DP_MUL) ? a_reg : x_reg;
    assign mul_b = (cmd.op == DP_MUL) ? b_reg : DIV10_RECIP;

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= 32'd0;
            rb_reg     <= 32'd0;
            halted_reg <= 1'b0;
            err_reg    <= ST_OK;
            clr_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                DP_EXEC:
                begin
                    case (oc)
                        IC_ADD, IC_MUL, IC_LT, IC_EQ: pc_reg <= pc_reg + 32'd4;
                        IC_IN, IC_OUT:                pc_reg <= pc_reg + 32'd2;
                        IC_JNZ, IC_JZ:
                        begin
                            pc_reg <= jump_taken ? b_reg : pc_reg + 32'd3;
                        end
                        IC_ARB:
                        begin
                            rb_reg <= rb_reg + a_reg;
                            pc_reg <= pc_reg + 32'd2;
                        end
                        default:
                        begin
                            pc_reg <= pc_reg;
                        end
                    endcase
                end
                DP_FINISH:
                begin
                    if (step_reg && cmd.code >= ST_BADOP)
                    begin
                        err_reg <= cmd.code;
                    end
                    if (step_reg && cmd.code == ST_HALT)
                    begin
                        halted_reg <= 1'b1;
                    end
                end
                default:
                begin
                    pc_reg <= pc_reg;
                end
            endcase
        end
    end

    // Working registers and result
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_CAPTURE:
            begin
                step_reg  <= item_data.opcode == OP_STEP;
                addr_reg  <= item_data.address;
                value_reg <= item_data.value;
                inv_reg   <= item_data.in_valid;
                inb_reg   <= item_data.in_byte;
            end
            DP_WORD:
            begin
                word_reg <= rdata;
                x_reg    <= rdata;
            end
            DP_DIV_MUL, DP_MUL:
            begin
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            DP_DIV_REM:
            begin
                x_reg   <= {3'b000, quot};
                dig_reg <= {rem, dig_reg[19:4]};
            end
            DP_OPND_RAW:
            begin
                if (cmd.dst)
                begin
                    d_reg <= eff[AW-1:0];
                end
                else if (cmd.idx == 2'd0)
                begin
                    a_reg <= rdata;
                end
                else
                begin
                    b_reg <= rdata;
                end
            end
            DP_OPND_VAL:
            begin
                if (cmd.idx == 2'd0)
                begin
                    a_reg <= rdata;
                end
                else
                begin
                    b_reg <= rdata;
                end
            end
            DP_FINISH:
            begin
                result_reg.status      <= cmd.code;
                result_reg.out_value   <= (cmd.code == ST_OUT) ? a_reg : 32'd0;
                result_reg.input_taken <= step_reg && cmd.code == ST_OK && oc == IC_IN;
                result_reg.next_pc     <= pc_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign result = result_reg;

endmodule

@@ rtl/icp_controller.sv @@
// Controller of the intcode core: sequences memory clear, loads, fetch,
// decimal decode, operand resolution, execute and result handoff.
// Depends on icp_pkg.
module icp_controller
    import icp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        C_CLEAR,
        C_IDLE,
        C_DISPATCH,
        C_WORD,
        C_DIVM,
        C_DIVR,
        C_DECODE,
        C_OADDR,
        C_ORAW,
        C_OVAL,
        C_NEXT,
        C_MUL,
        C_EXEC,
        C_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       dst_reg, dst_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign item_ready   = state_reg == C_IDLE;
    assign result_valid = out_valid_reg;
    assign slot_free    = !out_valid_reg || result_ready;

    // Next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd.op         = DP_NONE;
        cmd.idx        = idx_reg;
        cmd.dst        = dst_reg;
        cmd.code       = code_reg;

        unique case (state_reg)
            C_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = C_IDLE;
                end
            end
            C_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = C_DISPATCH;
                end
            end
            C_DISPATCH:
            begin
                state_next = C_FINISH;
                if (!stat.is_step)
                begin
                    if (stat.load_bad)
                    begin
                        code_next = ST_BADADDR;
                    end
                    else
                    begin
                        cmd.op    = DP_LOAD_WR;
                        code_next = ST_OK;
                    end
                end
                else if (stat.halted)
                begin
                    code_next = ST_HALT;
                end
                else if (stat.err != ST_OK)
                begin
                    code_next = stat.err;
                end
                else if (stat.fetch_bad)
                begin
                    code_next = ST_BADADDR;
                end
                else
                begin
                    cmd.op     = DP_FETCH;
                    state_next = C_WORD;
                end
            end
            C_WORD:
            begin
                cmd.op     = DP_WORD;
                cnt_next   = 3'd0;
                state_next = C_DIVM;
            end
            C_DIVM:
            begin
                cmd.op     = DP_DIV_MUL;
                state_next = C_DIVR;
            end
            C_DIVR:
            begin
                cmd.op   = DP_DIV_REM;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(NUM_DIGITS - 1))
                begin
                    state_next = C_DECODE;
                end
                else
                begin
                    state_next = C_DIVM;
                end
            end
            C_DECODE:
            begin
                idx_next   = 2'd0;
                dst_next   = 1'b0;
                state_next = C_OADDR;
                if (stat.word_neg)
                begin
                    code_next  = ST_BADOP;
                    state_next = C_FINISH;
                end
                else
                begin
                    case (stat.oc)
                        IC_ADD, IC_MUL, IC_LT, IC_EQ, IC_OUT, IC_JNZ, IC_JZ, IC_ARB:
                        begin
                            dst_next = 1'b0;
                        end
                        IC_IN:
                        begin
                            dst_next = 1'b1;
                            if (!stat.in_valid)
                            begin
                                code_next  = ST_WAIT;
                                state_next = C_FINISH;
                            end
                        end
                        IC_HALT:
                        begin
                            code_next  = ST_HALT;
                            state_next = C_FINISH;
                        end
                        default:
                        begin
                            code_next  = ST_BADOP;
                            state_next = C_FINISH;
                        end
                    endcase
                end
            end
            C_OADDR:
            begin
                if (stat.mode_bad)
                begin
                    code_next  = ST_BADMODE;
                    state_next = C_FINISH;
                end
                else if (stat.opnd_bad)
                begin
                    code_next  = ST_BADADDR;
                    state_next = C_FINISH;
                end
                else
                begin
                    cmd.op     = DP_OPND_ADDR;
                    state_next = C_ORAW;
                end
            end
            C_ORAW:
            begin
                cmd.op = DP_OPND_RAW;
                if (!dst_reg && stat.imm)
                begin
                    state_next = C_NEXT;
                end
                else if (stat.eff_bad)
                begin
                    code_next  = ST_BADADDR;
                    state_next = C_FINISH;
                end
                else if (dst_reg)
                begin
                    state_next = C_NEXT;
                end
                else
                begin
                    state_next = C_OVAL;
                end
            end
            C_OVAL:
            begin
                cmd.op     = DP_OPND_VAL;
                state_next = C_NEXT;
            end
            C_NEXT:
            begin
                state_next = C_EXEC;
                case (stat.oc)
                    IC_ADD, IC_MUL, IC_LT, IC_EQ:
                    begin
                        if (idx_reg == 2'd0)
                        begin
                            idx_next   = 2'd1;
                            state_next = C_OADDR;
                        end
                        else if (idx_reg == 2'd1)
                        begin
                            idx_next   = 2'd2;
                            dst_next   = 1'b1;
                            state_next = C_OADDR;
                        end
                        else if (stat.oc == IC_MUL)
                        begin
                            state_next = C_MUL;
                        end
                    end
                    IC_JNZ, IC_JZ:
                    begin
                        if (idx_reg == 2'd0 && stat.jump_taken)
                        begin
                            idx_next   = 2'd1;
                            state_next = C_OADDR;
                        end
                    end
                    default:
                    begin
                        state_next = C_EXEC;
                    end
                endcase
            end
            C_MUL:
            begin
                cmd.op     = DP_MUL;
                state_next = C_EXEC;
            end
            C_EXEC:
            begin
                cmd.op     = DP_EXEC;
                code_next  = (stat.oc == IC_OUT) ? ST_OUT : ST_OK;
                state_next = C_FINISH;
            end
            C_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.op         = DP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_CLEAR;
            idx_reg       <= 2'd0;
            dst_reg       <= 1'b0;
            cnt_reg       <= 3'd0;
            code_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/intcode_processor_core.sv @@
// Intcode processor core, top level: joins the controller and datapath to
// the item and result channels. Depends on icp_pkg, icp_chan_if,
// icp_controller and icp_datapath.
//
// After reset the core zeroes its whole word memory and accepts no item until
// that pass is done. A load item passes through dispatch and finish only. A
// step item's time is set by the word memory, with its one read port and
// registered read, and by the decimal decode, which extracts five digits with
// one shared 32x32 multiplier, a multiply step and a remainder step per digit;
// halt and early faults skip the later states. A new item is taken while the
// previous result still waits on the result channel; results are handed over
// in item order, exactly one per item.
module intcode_processor_core
    import icp_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    icp_chan_if.sink   item,
    icp_chan_if.source result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    item_t    item_data;
    result_t  result_data;

    assign item_data   = item.data;
    assign result.data = result_data;

    icp_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_ready  (item.ready),
        .result_valid(result.valid),
        .result_ready(result.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    icp_datapath #(
        .MEM_WORDS(MEM_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item_data(item_data),
        .stat     (stat),
        .result   (result_data)
    );

endmodule

@@ bench/tb.sv @@
// Testbench for intcode_processor_core: drives load and step transfers, predicts every
// result with an independent instruction model and checks the result channel field by field.
// Depends on icp_pkg, icp_chan_if and the core RTL.
module tb;
    import icp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS      = MEM_WORDS_DEF;
    localparam int CYCLE_MAX  = 1000000;
    localparam int ITEM_GOAL  = 1740;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;

    logic clk;
    logic rst_n;

    icp_chan_if #(.T(item_t))   item_ch ();
    icp_chan_if #(.T(result_t)) result_ch ();

    intcode_processor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Shadow machine state
    logic [31:0] vm_mem [WORDS];
    logic [31:0] vm_pc;
    logic [31:0] vm_rb;
    logic        vm_halted;
    logic [2:0]  vm_err;
    longint      vm_word;

    item_t   pending_items [$];
    result_t expected_results [$];

    int mismatch_cnt;
    int sent_cnt;
    int checked_cnt;
    int cycle_cnt;
    int hold_cnt;
    bit hold_done;
    int out_cnt;
    int wait_cnt;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Memory word read with range check
    function automatic logic [2:0] vm_read(input logic [31:0] a, output logic [31:0] v);
        v = '0;
        if (a >= WORDS)
            return ST_BADADDR;
        v = vm_mem[a];
        return ST_OK;
    endfunction

    function automatic longint mode_of(input int idx);
        longint wt;
        wt = (idx == 0) ? 100 : (idx == 1) ? 1000 : 10000;
        return (vm_word / wt) % 10;
    endfunction

    function automatic logic [2:0] fetch_src(input int idx, output logic [31:0] v);
        longint      m;
        logic [31:0] raw;
        logic [2:0]  e;
        v = '0;
        m = mode_of(idx);
        if (m != MD_POS && m != MD_IMM && m != MD_REL)
            return ST_BADMODE;
        e = vm_read(vm_pc + idx + 1, raw);
        if (e != ST_OK)
            return e;
        if (m == MD_IMM)
        begin
            v = raw;
            return ST_OK;
        end
        if (m == MD_REL)
            raw = vm_rb + raw;
        return vm_read(raw, v);
    endfunction

    function automatic logic [2:0] fetch_dst(input int idx, output logic [31:0] a);
        longint      m;
        logic [31:0] raw;
        logic [2:0]  e;
        a = '0;
        m = mode_of(idx);
        if (m != MD_POS && m != MD_REL)
            return ST_BADMODE;
        e = vm_read(vm_pc + idx + 1, raw);
        if (e != ST_OK)
            return e;
        if (m == MD_REL)
            raw = vm_rb + raw;
        if (raw >= WORDS)
            return ST_BADADDR;
        a = raw;
        return ST_OK;
    endfunction

    // Execute one instruction on the shadow state
    function automatic logic [2:0] run_instr(input logic inv, input logic [7:0] inb,
                                             output logic [31:0] outv, output logic taken);
        logic [31:0] w, a, b, d;
        logic [2:0]  e;
        longint      oc;
        outv  = '0;
        taken = 1'b0;
        e = vm_read(vm_pc, w);
        if (e != ST_OK)
            return e;
        vm_word = longint'($signed(w));
        oc = vm_word % 100;
        if (oc == IC_ADD || oc == IC_MUL || oc == IC_LT || oc == IC_EQ)
        begin
            e = fetch_src(0, a);
            if (e != ST_OK) return e;
            e = fetch_src(1, b);
            if (e != ST_OK) return e;
            e = fetch_dst(2, d);
            if (e != ST_OK) return e;
            if (oc == IC_ADD)
                vm_mem[d] = a + b;
            else if (oc == IC_MUL)
                vm_mem[d] = a * b;
            else if (oc == IC_LT)
                vm_mem[d] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            else
                vm_mem[d] = (a == b) ? 32'd1 : 32'd0;
            vm_pc = vm_pc + 4;
            return ST_OK;
        end
        if (oc == IC_IN)
        begin
            if (!inv)
                return ST_WAIT;
            e = fetch_dst(0, d);
            if (e != ST_OK) return e;
            vm_mem[d] = {24'd0, inb};
            taken = 1'b1;
            vm_pc = vm_pc + 2;
            return ST_OK;
        end
        if (oc == IC_OUT)
        begin
            e = fetch_src(0, a);
            if (e != ST_OK) return e;
            outv = a;
            vm_pc = vm_pc + 2;
            return ST_OUT;
        end
        if (oc == IC_JNZ || oc == IC_JZ)
        begin
            e = fetch_src(0, a);
            if (e != ST_OK) return e;
            if ((a != 0) == (oc == IC_JNZ))
            begin
                e = fetch_src(1, b);
                if (e != ST_OK) return e;
                vm_pc = b;
            end
            else
                vm_pc = vm_pc + 3;
            return ST_OK;
        end
        if (oc == IC_ARB)
        begin
            e = fetch_src(0, a);
            if (e != ST_OK) return e;
            vm_rb = vm_rb + a;
            vm_pc = vm_pc + 2;
            return ST_OK;
        end
        if (oc == IC_HALT)
        begin
            vm_halted = 1'b1;
            return ST_HALT;
        end
        return ST_BADOP;
    endfunction

    // Advance the shadow machine by one transfer and queue its expected result
    task automatic queue_item(input item_t it);
        result_t r;
        logic [31:0] outv;
        logic        taken;
        outv  = '0;
        taken = 1'b0;
        if (it.opcode == OP_LOAD)
        begin
            vm_mem[it.address] = it.value;
            r.status = ST_OK;
        end
        else if (vm_halted)
            r.status = ST_HALT;
        else if (vm_err != ST_OK)
            r.status = vm_err;
        else
        begin
            r.status = run_instr(it.in_valid, it.in_byte, outv, taken);
            if (r.status >= ST_BADOP)
            begin
                vm_err = r.status;
                taken  = 1'b0;
            end
        end
        r.out_value   = outv;
        r.input_taken = taken;
        r.next_pc     = vm_pc;
        pending_items.push_back(it);
        expected_results.push_back(r);
    endtask

    task automatic put_load(input logic [31:0] addr, input logic [31:0] val);
        item_t it;
        it.opcode   = OP_LOAD;
        it.address  = addr[11:0];
        it.value    = val;
        it.in_valid = 1'($urandom_range(0, 1));
        it.in_byte  = 8'($urandom);
        queue_item(it);
    endtask

    task automatic put_step(input logic inv);
        item_t it;
        it.opcode   = OP_STEP;
        it.address  = 12'($urandom);
        it.value    = $urandom;
        it.in_valid = inv;
        it.in_byte  = 8'($urandom);
        queue_item(it);
    endtask

    function automatic logic [31:0] pick_data(input bit extreme);
        int k;
        if (!extreme)
            return $urandom;
        k = $urandom_range(0, 4);
        case (k)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            default: return 32'd1;
        endcase
    endfunction

    // Pick a data address away from the instruction words at p and from avoid
    function automatic logic [31:0] pick_addr(input logic [31:0] p, input logic [31:0] avoid);
        logic [31:0] ad;
        do
            ad = $urandom_range(0, WORDS - 1);
        while ((ad >= p && ad <= p + 3) || ad == avoid);
        return ad;
    endfunction

    // Lay down one well-formed instruction at the current pc with its data, then step it
    task automatic emit_instr(input int oc, input bit extreme, input logic inv);
        int          nparm;
        int          md [3];
        logic [31:0] p, ad, val, raw, prev;
        longint      w;
        bit          is_dst;
        p = vm_pc;
        if (p > 4000)
        begin
            // Pull pc back into low memory first
            put_load(p, 32'd1105);
            put_load(p + 1, 32'd1);
            put_load(p + 2, $urandom_range(0, 3999));
            put_step(1'($urandom_range(0, 1)));
            p = vm_pc;
        end
        nparm = (oc == IC_ADD || oc == IC_MUL || oc == IC_LT || oc == IC_EQ) ? 3 :
                (oc == IC_JNZ || oc == IC_JZ) ? 2 : 1;
        for (int i = 0; i < 3; i++)
            md[i] = (i < nparm) ? $urandom_range(0, 2) : $urandom_range(0, 9);
        if (nparm == 3 && md[2] == MD_IMM)
            md[2] = MD_REL;
        if (oc == IC_IN && md[0] == MD_IMM)
            md[0] = MD_POS;
        w = oc + md[0] * 100 + md[1] * 1000 + md[2] * 10000;
        if ($urandom_range(0, 3) == 0)
            w = w + longint'($urandom_range(0, 21000)) * 100000;
        put_load(p, 32'(w));
        prev = 32'hFFFF_FFFF;
        for (int i = 0; i < nparm; i++)
        begin
            is_dst = (nparm == 3 && i == 2) || oc == IC_IN;
            ad  = pick_addr(p, prev);
            prev = ad;
            val = pick_data(extreme);
            if (oc == IC_JNZ || oc == IC_JZ)
            begin
                if (i == 1)
                    val = $urandom_range(0, 3999);
                else if ($urandom_range(0, 2) == 0)
                    val = 32'd0;
            end
            if (oc == IC_ARB && extreme)
                val = 32'h8000_0000;
            if (md[i] == MD_IMM)
                raw = val;
            else if (md[i] == MD_REL)
                raw = ad - vm_rb;
            else
                raw = ad;
            put_load(p + i + 1, raw);
            if (!is_dst && md[i] != MD_IMM)
                put_load(ad, val);
        end
        put_step(inv);
    endtask

    // Build the whole stimulus, ending with one latched fault
    task automatic build_stimulus();
        int k, fault;
        logic [31:0] p;
        // Directed: each instruction once with extreme data, plus input waiting
        for (int oc = 1; oc <= 9; oc++)
            emit_instr(oc, 1'b1, 1'b1);
        emit_instr(IC_IN, 1'b0, 1'b0);
        put_load(32'd4095, 32'h7FFF_FFFF);
        put_load(32'd4095, 32'h8000_0000);
        // Random: well-formed instructions with stray loads as noise
        while (pending_items.size() < ITEM_GOAL)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                put_load($urandom, $urandom);
            else
                emit_instr($urandom_range(1, 9), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 9) != 0);
        end
        // Final fault, then steps that see it latched
        p = vm_pc;
        if (p > 4000)
        begin
            emit_instr(IC_JNZ, 1'b0, 1'b1);
            p = vm_pc;
        end
        fault = $urandom_range(0, 5);
        case (fault)
            0: put_load(p, 32'd99);
            1: put_load(p, 32'd42);
            2: put_load(p, -32'sd1202);
            3:
            begin
                put_load(p, 32'd11101);
                put_load(p + 1, 32'd5);
                put_load(p + 2, 32'd6);
                put_load(p + 3, 32'd7);
            end
            4:
            begin
                put_load(p, 32'd4);
                put_load(p + 1, 32'd4096 + $urandom_range(0, 100000));
            end
            default:
            begin
                put_load(p, 32'd1105);
                put_load(p + 1, 32'd1);
                put_load(p + 2, 32'hFFFF_F000 | $urandom_range(0, 4095));
                put_step(1'b1);
            end
        endcase
        put_step(1'b1);
        put_step(1'b0);
        put_load($urandom, $urandom);
        for (int i = 0; i < 4; i++)
            put_step(1'($urandom_range(0, 1)));
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d", checked_cnt, field, got,
                 want);
        mismatch_cnt++;
    endtask

    // Idle percentage for each side, by phase of the run
    function automatic int send_idle_pct();
        return (sent_cnt < 600) ? 23 : (sent_cnt < 1200) ? 72 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (sent_cnt < 600) ? 72 : (sent_cnt < 1200) ? 23 : 0;
    endfunction

    // Item driver: hold the payload until the transfer, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                sent_cnt <= sent_cnt + 1;
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= pending_items.pop_front();
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        else if (!hold_done && sent_cnt >= HOLD_AT)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Result ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_results.size() == 0)
            begin
                $display("unexpected result, status %0d", got.status);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.out_value != want.out_value)
                    report_mismatch("out_value", got.out_value, want.out_value);
                if (got.input_taken != want.input_taken)
                    report_mismatch("input_taken", got.input_taken, want.input_taken);
                if (got.next_pc != want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.status == ST_OUT)
                    out_cnt++;
                if (got.status == ST_WAIT)
                    wait_cnt++;
            end
            checked_cnt++;
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int total;
        mismatch_cnt = 0;
        sent_cnt     = 0;
        checked_cnt  = 0;
        cycle_cnt    = 0;
        out_cnt      = 0;
        wait_cnt     = 0;
        for (int i = 0; i < WORDS; i++)
            vm_mem[i] = '0;
        vm_pc     = '0;
        vm_rb     = '0;
        vm_halted = 1'b0;
        vm_err    = ST_OK;
        vm_word   = 0;
        rst_n     = 1'b0;
        build_stimulus();
        total = pending_items.size();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("ran %0d transfers, checked %0d results (%0d outputs, %0d input waits)",
                 total, checked_cnt, out_cnt, wait_cnt);
        $display("final fault status %0d, halted %0b", vm_err, vm_halted);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
